/* sv/oppr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oppr_pkg
// Types and constants shared by the offset pair proximity rejector.
// ----------------------------------------------------------------------------
package oppr_pkg;

	localparam int COMP_W   = 7;
	localparam int IDX_W    = 12;
	localparam int LIMIT_W  = 15;
	localparam int TARGET_W = 13;
	localparam int SCOUNT_W = 13;
	localparam int MISS_W   = 32;
	localparam int IN_DW    = 40;
	localparam int OUT_DW   = 80;
	localparam int CFG_DW   = 15;
	localparam int CFG_IW   = 1;

	localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 15'd25;
	localparam logic [TARGET_W-1:0] TARGET_RST = 13'd4000;

	localparam logic CMD_READ = 1'b1;

	localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
	localparam logic [1:0] STATUS_REJECTED = 2'd1;
	localparam logic [1:0] STATUS_FULL     = 2'd2;
	localparam logic [1:0] STATUS_READ     = 2'd3;

	localparam logic [CFG_IW-1:0] REG_DISTANCE_SQ_LIMIT = 1'd0;
	localparam logic [CFG_IW-1:0] REG_TARGET_COUNT      = 1'd1;

	typedef struct packed {
		logic [COMP_W-1:0] v_y;
		logic [COMP_W-1:0] v_x;
		logic [COMP_W-1:0] u_y;
		logic [COMP_W-1:0] u_x;
	} pair_t;

	localparam int PAIR_W = $bits(pair_t);
	localparam int PAD_W  = OUT_DW - SCOUNT_W - MISS_W - PAIR_W;

endpackage
`default_nettype wire

/* sv/offset_pair_proximity_rejector.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// offset_pair_proximity_rejector
// Minimum distance rejection over a store of accepted offset pairs.
// ----------------------------------------------------------------------------
// An offer walks the pair store through its single read port, one stored pair
// per cycle, and resolves when a close pair turns up or the last one is
// checked; a refused offer on a full store and a read beyond the held pairs
// go straight to the result, and a read of a held pair first waits for the
// store's registered read data. The result sits in an output register, so
// the next item is taken while it waits. The store needs no clearing after
// reset: only entries below the pair count are ever read.
module offset_pair_proximity_rejector #(
	parameter int CAPACITY = 4096
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// u_x[6:0], u_y[13:7], v_x[20:14], v_y[27:21], read_index[39:28]
	input  wire  [oppr_pkg::IN_DW-1:0]       s_tdata,
	// command[0]
	input  wire                              s_tuser,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// stored_count[12:0], miss_count[44:13], out_u_x[51:45], out_u_y[58:52],
	// out_v_x[65:59], out_v_y[72:66], zero[79:73]
	output logic [oppr_pkg::OUT_DW-1:0]      m_tdata,
	// status[1:0]
	output logic [1:0]                       m_tuser,
	input  wire                              cfg_we,
	input  wire  [oppr_pkg::CFG_IW-1:0]      cfg_index,
	input  wire  [oppr_pkg::CFG_DW-1:0]      cfg_data
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int WW = (CW > oppr_pkg::SCOUNT_W) ? CW : oppr_pkg::SCOUNT_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RDWAIT,
		S_DONE
	} state_t;

	state_t                           state_q;
	logic [oppr_pkg::LIMIT_W-1:0]     limit_q;
	logic [oppr_pkg::TARGET_W-1:0]    target_q;
	logic [CW-1:0]                    count_q;
	logic [oppr_pkg::MISS_W-1:0]      miss_q;
	logic [CW-1:0]                    scan_q;
	logic                             rd_vld_q;
	oppr_pkg::pair_t                  cand_q;
	oppr_pkg::pair_t                  res_pair_q;
	logic [1:0]                       res_status_q;
	logic                             m_tvalid_q;
	logic [1:0]                       m_tuser_q;
	logic [oppr_pkg::OUT_DW-1:0]      m_tdata_q;

	logic                             in_accept;
	logic                             in_is_read;
	oppr_pkg::pair_t                  in_pair;
	logic [WW-1:0]                    in_idx;
	logic [WW-1:0]                    count_w;
	logic                             full;
	logic                             idx_hit;
	logic                             scan_more;
	logic                             close;
	logic                             out_ready;
	logic [15:0]                      du;
	logic [15:0]                      dv;

	logic                             ram_we;
	logic                             ram_re;
	logic [AW-1:0]                    ram_raddr;
	logic [oppr_pkg::PAIR_W-1:0]      ram_rdata_raw;
	oppr_pkg::pair_t                  ram_rdata;

	function automatic logic [15:0] sq_dist(
		input logic [oppr_pkg::COMP_W-1:0] ax,
		input logic [oppr_pkg::COMP_W-1:0] ay,
		input logic [oppr_pkg::COMP_W-1:0] bx,
		input logic [oppr_pkg::COMP_W-1:0] by
	);
		logic signed [7:0]  dx;
		logic signed [7:0]  dy;
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		dx = $signed({ax[6], ax}) - $signed({bx[6], bx});
		dy = $signed({ay[6], ay}) - $signed({by[6], by});
		sx = 16'(dx) * 16'(dx);
		sy = 16'(dy) * 16'(dy);
		return 16'($unsigned(sx) + $unsigned(sy));
	endfunction

	assign s_tready   = (state_q == S_IDLE);
	assign in_accept  = s_tvalid && s_tready;
	assign in_is_read = (s_tuser == oppr_pkg::CMD_READ);
	assign in_pair    = oppr_pkg::pair_t'(s_tdata[oppr_pkg::PAIR_W-1:0]);
	assign in_idx     = WW'(s_tdata[oppr_pkg::PAIR_W +: oppr_pkg::IDX_W]);
	assign count_w    = WW'(count_q);
	assign full       = (count_w >= WW'(target_q)) || (count_q >= CW'(CAPACITY));
	assign idx_hit    = (in_idx < count_w);
	assign scan_more  = (scan_q < count_q);
	assign out_ready  = !m_tvalid_q || m_tready;

	assign ram_rdata = oppr_pkg::pair_t'(ram_rdata_raw);
	assign du = sq_dist(ram_rdata.u_x, ram_rdata.u_y, cand_q.u_x, cand_q.u_y);
	assign dv = sq_dist(ram_rdata.v_x, ram_rdata.v_y, cand_q.v_x, cand_q.v_y);
	assign close = rd_vld_q && (du < {1'b0, limit_q}) && (dv < {1'b0, limit_q});

	assign ram_re = (in_accept && in_is_read && idx_hit) ||
	                ((state_q == S_SCAN) && !close && scan_more);
	assign ram_raddr = (state_q == S_IDLE) ? in_idx[AW-1:0] : scan_q[AW-1:0];
	assign ram_we = (state_q == S_SCAN) && !close && !scan_more;

	oppr_ram #(
		.WIDTH (oppr_pkg::PAIR_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (cand_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			limit_q    <= oppr_pkg::LIMIT_RST;
			target_q   <= oppr_pkg::TARGET_RST;
			count_q    <= '0;
			miss_q     <= '0;
			scan_q     <= '0;
			rd_vld_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					oppr_pkg::REG_DISTANCE_SQ_LIMIT: limit_q <= cfg_data[oppr_pkg::LIMIT_W-1:0];
					oppr_pkg::REG_TARGET_COUNT: target_q <= cfg_data[oppr_pkg::TARGET_W-1:0];
					default: ;
				endcase
			end

			if ((state_q == S_DONE) && out_ready) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					rd_vld_q <= 1'b0;
					if (in_accept) begin
						cand_q     <= in_pair;
						res_pair_q <= '0;
						scan_q     <= '0;
						if (in_is_read) begin
							res_status_q <= oppr_pkg::STATUS_READ;
							state_q      <= idx_hit ? S_RDWAIT : S_DONE;
						end else if (full) begin
							res_status_q <= oppr_pkg::STATUS_FULL;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					rd_vld_q <= ram_re;
					if (close) begin
						res_status_q <= oppr_pkg::STATUS_REJECTED;
						if (miss_q != '1) begin
							miss_q <= miss_q + 1'b1;
						end
						state_q <= S_DONE;
					end else if (scan_more) begin
						scan_q <= scan_q + 1'b1;
					end else begin
						count_q      <= count_q + 1'b1;
						res_status_q <= oppr_pkg::STATUS_ACCEPTED;
						state_q      <= S_DONE;
					end
				end
				S_RDWAIT: begin
					res_pair_q <= ram_rdata;
					state_q    <= S_DONE;
				end
				S_DONE: begin
					rd_vld_q <= 1'b0;
					if (out_ready) begin
						m_tuser_q  <= res_status_q;
						m_tdata_q  <= {{oppr_pkg::PAD_W{1'b0}}, res_pair_q, miss_q,
						               count_w[oppr_pkg::SCOUNT_W-1:0]};
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("pair count beyond capacity");

	a_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("store written and read in the same cycle");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (scan_q <= count_q))
		else $error("scan pointer past the pair count");

	a_miss_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (miss_q >= $past(miss_q)))
		else $error("miss counter decreased");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> (count_q == $past(count_q) + CW'(1)))
		else $error("append without pair count step");
`endif

endmodule
`default_nettype wire

/* sv/oppr_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oppr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module oppr_ram #(
	parameter int WIDTH = 28,
	parameter int DEPTH = 4096
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire
